// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the segment allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define FFSA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: check failed");

// clocked check with its own message
`define FFSA_ASSERT_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

`endif

// ----- hdl/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types, codes and the control store of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int SIZE_W   = 11;
    localparam int ADDR_W   = 10;
    localparam int STATUS_W = 3;
    localparam int STEP_W   = 4;

    // managed memory never exceeds this many words
    localparam logic [SIZE_W-1:0] MEM_WORDS = 11'd1024;
    localparam logic [SIZE_W-1:0] MEM_WORDS_RESET = 11'd1024;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // program addresses
    localparam logic [STEP_W-1:0] S_INIT   = 4'd0;
    localparam logic [STEP_W-1:0] S_IDLE   = 4'd1;
    localparam logic [STEP_W-1:0] S_SETUP  = 4'd2;
    localparam logic [STEP_W-1:0] S_BADCHK = 4'd3;
    localparam logic [STEP_W-1:0] S_MERGE  = 4'd4;
    localparam logic [STEP_W-1:0] S_MFIN   = 4'd5;
    localparam logic [STEP_W-1:0] S_DECIDE = 4'd6;
    localparam logic [STEP_W-1:0] S_SHSET  = 4'd7;
    localparam logic [STEP_W-1:0] S_SHIFT  = 4'd8;
    localparam logic [STEP_W-1:0] S_INS    = 4'd9;
    localparam logic [STEP_W-1:0] S_MARK   = 4'd10;
    localparam logic [STEP_W-1:0] S_FSCAN  = 4'd11;
    localparam logic [STEP_W-1:0] S_DONE   = 4'd12;

    typedef enum logic [3:0] {
        A_NONE, A_INIT, A_LATCH, A_SETUP, A_MERGE, A_MFIN, A_DECIDE,
        A_SHSET, A_SHIFT, A_INSERT, A_MARK, A_FSCAN, A_EMIT
    } t_action;

    typedef enum logic [3:0] {
        C_NONE, C_ALWAYS, C_ACCEPT, C_IS_FREE, C_BAD_SIZE, C_MERGE_DONE,
        C_NO_SPLIT, C_SHIFT_DONE, C_FSCAN_DONE, C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_action            action;
        t_cond              cond;
        logic               hold;    // stay on this step while cond is false
        logic [STEP_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic is_free;
        logic bad_size;
        logic merge_done;
        logic no_split;
        logic shift_done;
        logic fscan_done;
        logic out_free;
    } t_flags;

    typedef struct packed {
        t_action           action;
    } t_uctl;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic              free;
    } t_seg;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            S_INIT:   w = '{A_INIT,   C_ALWAYS,     1'b0, S_IDLE};
            S_IDLE:   w = '{A_LATCH,  C_ACCEPT,     1'b1, S_SETUP};
            S_SETUP:  w = '{A_SETUP,  C_IS_FREE,    1'b0, S_FSCAN};
            S_BADCHK: w = '{A_NONE,   C_BAD_SIZE,   1'b0, S_DONE};
            S_MERGE:  w = '{A_MERGE,  C_MERGE_DONE, 1'b1, S_MFIN};
            S_MFIN:   w = '{A_MFIN,   C_NONE,       1'b0, S_DECIDE};
            S_DECIDE: w = '{A_DECIDE, C_NO_SPLIT,   1'b0, S_MARK};
            S_SHSET:  w = '{A_SHSET,  C_NONE,       1'b0, S_SHIFT};
            S_SHIFT:  w = '{A_SHIFT,  C_SHIFT_DONE, 1'b1, S_INS};
            S_INS:    w = '{A_INSERT, C_NONE,       1'b0, S_MARK};
            S_MARK:   w = '{A_MARK,   C_ALWAYS,     1'b0, S_DONE};
            S_FSCAN:  w = '{A_FSCAN,  C_FSCAN_DONE, 1'b1, S_DONE};
            S_DONE:   w = '{A_EMIT,   C_OUT_FREE,   1'b1, S_IDLE};
            default:  w = '{A_NONE,   C_ALWAYS,     1'b0, S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/ffsa_in_if.sv -----
// ----------------------------------------------------------------------------
// ffsa_in_if
// Request channel: opcode, allocate size and free address.
// ----------------------------------------------------------------------------
interface ffsa_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [ffsa_pkg::SIZE_W-1:0]   alloc_size;
    logic [ffsa_pkg::ADDR_W-1:0]   free_address;

    modport source (output valid, output opcode, output alloc_size,
                    output free_address, input ready);
    modport sink   (input valid, input opcode, input alloc_size,
                    input free_address, output ready);
endinterface

// ----- hdl/ffsa_out_if.sv -----
// ----------------------------------------------------------------------------
// ffsa_out_if
// Response channel: status and granted address.
// ----------------------------------------------------------------------------
interface ffsa_out_if;
    logic                          valid;
    logic                          ready;
    logic [ffsa_pkg::STATUS_W-1:0] status;
    logic [ffsa_pkg::ADDR_W-1:0]   granted_address;

    modport source (output valid, output status, output granted_address,
                    input ready);
    modport sink   (input valid, input status, input granted_address,
                    output ready);
endinterface

// ----- hdl/ffsa_useq.sv -----
// ----------------------------------------------------------------------------
// ffsa_useq
// Microprogram sequencer: step counter, control store, conditional jumps.
// ----------------------------------------------------------------------------
module ffsa_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffsa_pkg::t_flags  i_flags,
    output ffsa_pkg::t_uctl   o_ctl
);

    logic [ffsa_pkg::STEP_W-1:0] r_step;
    logic [ffsa_pkg::STEP_W-1:0] n_step;
    ffsa_pkg::t_uword            uw;
    logic                        take;

    assign uw = ffsa_pkg::ucode(r_step);

    always_comb begin
        case (uw.cond)
            ffsa_pkg::C_NONE:       take = 1'b0;
            ffsa_pkg::C_ALWAYS:     take = 1'b1;
            ffsa_pkg::C_ACCEPT:     take = i_flags.accept;
            ffsa_pkg::C_IS_FREE:    take = i_flags.is_free;
            ffsa_pkg::C_BAD_SIZE:   take = i_flags.bad_size;
            ffsa_pkg::C_MERGE_DONE: take = i_flags.merge_done;
            ffsa_pkg::C_NO_SPLIT:   take = i_flags.no_split;
            ffsa_pkg::C_SHIFT_DONE: take = i_flags.shift_done;
            ffsa_pkg::C_FSCAN_DONE: take = i_flags.fscan_done;
            ffsa_pkg::C_OUT_FREE:   take = i_flags.out_free;
            default:                take = 1'b0;
        endcase
    end

    always_comb begin
        if (take) begin
            n_step = uw.target;
        end else if (uw.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ffsa_pkg::S_INIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl.action = uw.action;

endmodule

// ----- hdl/first_fit_segment_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over an ordered table of contiguous memory segments.
// ----------------------------------------------------------------------------
// A microcoded sequencer walks a segment table with one read and one write
// per cycle (registered read). After reset an init step sets the table to a
// single free segment; no request is taken before that. An allocate of
// nonzero size does one merge-and-search pass over the segments held, which
// joins neighbouring free segments and finds the first that fits; when that
// segment is split, the entries above it move up by one to open a gap for
// the remainder. A free scans the table for the segment that starts at the
// given address; a zero-size allocate skips both passes. One request is in
// work at a time; a finished result sits in an output register, so the next
// request transfers in while it waits to be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ffsa_pkg::SIZE_W-1:0]  i_cfg_data,
    ffsa_in_if.sink                      i_req,
    ffsa_out_if.source                   o_rsp
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = ffsa_pkg::ADDR_W;
    localparam int SW = ffsa_pkg::SIZE_W;
    localparam int TW = ffsa_pkg::STATUS_W;

    // segment table
    ffsa_pkg::t_seg mem [MAX_SEGMENTS];

    ffsa_pkg::t_uctl  ctl;
    ffsa_pkg::t_flags flags;

    logic [SW-1:0] r_mem_words, n_mem_words;
    logic          r_op, n_op;
    logic [SW-1:0] r_size, n_size;
    logic [AW-1:0] r_faddr, n_faddr;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd, n_rd;
    logic          r_dv, n_dv;
    logic [IW-1:0] r_didx, n_didx;
    logic [CW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_prev_s, n_prev_s;
    logic          r_prev_f, n_prev_f;
    logic          r_fit_found, n_fit_found;
    logic [IW-1:0] r_fit_idx, n_fit_idx;
    logic [AW-1:0] r_fit_start, n_fit_start;
    logic [SW-1:0] r_fit_len, n_fit_len;
    logic [TW-1:0] r_status, n_status;
    logic [AW-1:0] r_grant, n_grant;
    logic          r_ovalid, n_ovalid;
    logic [TW-1:0] r_ostatus, n_ostatus;
    logic [AW-1:0] r_ogrant, n_ogrant;
    ffsa_pkg::t_seg r_rdata;

    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    ffsa_pkg::t_seg mem_wdata;
    logic           rd_en;

    logic           accept;
    logic [SW-1:0]  mem_end;
    logic [SW-1:0]  seg_len;
    logic [SW-1:0]  end_len;
    logic           up_issue;
    logic           dn_issue;
    logic           match;
    logic           table_full;
    logic           skip;
    logic [CW-1:0]  wr_m1;
    logic [IW-1:0]  ins_idx;

    assign accept     = i_req.valid && i_req.ready;
    assign mem_end    = (r_mem_words > ffsa_pkg::MEM_WORDS) ? ffsa_pkg::MEM_WORDS
                                                            : r_mem_words;
    assign seg_len    = (r_rdata.start > r_prev_s)
                        ? ({1'b0, r_rdata.start} - {1'b0, r_prev_s}) : '0;
    assign end_len    = (mem_end > {1'b0, r_prev_s}) ? (mem_end - {1'b0, r_prev_s})
                                                     : '0;
    assign up_issue   = (r_rd < r_count);
    assign dn_issue   = (r_rd > CW'(r_fit_idx));
    assign match      = r_dv && (r_rdata.start == r_faddr);
    assign table_full = (r_count >= CW'(MAX_SEGMENTS));
    assign skip       = (r_wr != '0) && r_rdata.free && r_prev_f;
    assign wr_m1      = r_wr - CW'(1);
    assign ins_idx    = r_fit_idx + IW'(1);

    assign flags.accept     = accept;
    assign flags.is_free    = (r_op == ffsa_pkg::OP_FREE);
    assign flags.bad_size   = (r_status == ffsa_pkg::ST_BAD_SIZE);
    assign flags.merge_done = !up_issue && !r_dv;
    assign flags.no_split   = !r_fit_found || (r_fit_len == r_size) || table_full;
    assign flags.shift_done = !dn_issue && !r_dv;
    assign flags.fscan_done = match || (!up_issue && !r_dv);
    assign flags.out_free   = !r_ovalid || o_rsp.ready;

    ffsa_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    assign i_req.ready = (ctl.action == ffsa_pkg::A_LATCH);

    always_comb begin
        n_mem_words = i_cfg_we ? i_cfg_data : r_mem_words;
        n_op        = r_op;
        n_size      = r_size;
        n_faddr     = r_faddr;
        n_count     = r_count;
        n_rd        = r_rd;
        n_dv        = r_dv;
        n_didx      = r_didx;
        n_wr        = r_wr;
        n_prev_s    = r_prev_s;
        n_prev_f    = r_prev_f;
        n_fit_found = r_fit_found;
        n_fit_idx   = r_fit_idx;
        n_fit_start = r_fit_start;
        n_fit_len   = r_fit_len;
        n_status    = r_status;
        n_grant     = r_grant;
        n_ovalid    = r_ovalid && !o_rsp.ready;
        n_ostatus   = r_ostatus;
        n_ogrant    = r_ogrant;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        rd_en       = 1'b0;

        case (ctl.action)
            ffsa_pkg::A_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = '{start: '0, free: 1'b1};
            end
            ffsa_pkg::A_LATCH: begin
                if (accept) begin
                    n_op    = i_req.opcode;
                    n_size  = i_req.alloc_size;
                    n_faddr = i_req.free_address;
                end
            end
            ffsa_pkg::A_SETUP: begin
                if (r_op == ffsa_pkg::OP_FREE) begin
                    n_status = ffsa_pkg::ST_NOT_FOUND;
                end else if (r_size == '0) begin
                    n_status = ffsa_pkg::ST_BAD_SIZE;
                end else begin
                    n_status = ffsa_pkg::ST_OK;
                end
                n_grant     = '0;
                n_rd        = '0;
                n_dv        = 1'b0;
                n_wr        = '0;
                n_fit_found = 1'b0;
            end
            ffsa_pkg::A_MERGE: begin
                // read entry r while compacting the entry read last cycle
                rd_en = up_issue;
                n_dv  = up_issue;
                if (up_issue) begin
                    n_rd = r_rd + CW'(1);
                end
                if (r_dv && !skip) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr[IW-1:0];
                    mem_wdata = r_rdata;
                    // the previous kept segment now has a known end
                    if ((r_wr != '0) && r_prev_f && !r_fit_found && (seg_len >= r_size)) begin
                        n_fit_found = 1'b1;
                        n_fit_idx   = wr_m1[IW-1:0];
                        n_fit_start = r_prev_s;
                        n_fit_len   = seg_len;
                    end
                    n_prev_s = r_rdata.start;
                    n_prev_f = r_rdata.free;
                    n_wr     = r_wr + CW'(1);
                end
            end
            ffsa_pkg::A_MFIN: begin
                // last segment runs to the memory end
                if (r_prev_f && !r_fit_found && (end_len >= r_size)) begin
                    n_fit_found = 1'b1;
                    n_fit_idx   = wr_m1[IW-1:0];
                    n_fit_start = r_prev_s;
                    n_fit_len   = end_len;
                end
                n_count = r_wr;
            end
            ffsa_pkg::A_DECIDE: begin
                if (!r_fit_found) begin
                    n_status = ffsa_pkg::ST_NO_SPACE;
                end else if ((r_fit_len != r_size) && table_full) begin
                    n_status = ffsa_pkg::ST_TABLE_FULL;
                end else begin
                    n_status = ffsa_pkg::ST_OK;
                    n_grant  = r_fit_start;
                end
            end
            ffsa_pkg::A_SHSET: begin
                n_rd    = r_count - CW'(1);
                n_wr    = r_count;
                n_dv    = 1'b0;
                n_count = r_count + CW'(1);
            end
            ffsa_pkg::A_SHIFT: begin
                // move entries up by one, top first
                rd_en = dn_issue;
                n_dv  = dn_issue;
                if (dn_issue) begin
                    n_rd = r_rd - CW'(1);
                end
                if (r_dv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr[IW-1:0];
                    mem_wdata = r_rdata;
                    n_wr      = r_wr - CW'(1);
                end
            end
            ffsa_pkg::A_INSERT: begin
                mem_we    = 1'b1;
                mem_waddr = ins_idx;
                mem_wdata = '{start: r_fit_start + r_size[AW-1:0], free: 1'b1};
            end
            ffsa_pkg::A_MARK: begin
                if (r_status == ffsa_pkg::ST_OK) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_fit_idx;
                    mem_wdata = '{start: r_fit_start, free: 1'b0};
                end
            end
            ffsa_pkg::A_FSCAN: begin
                rd_en = up_issue;
                n_dv  = up_issue;
                if (up_issue) begin
                    n_rd   = r_rd + CW'(1);
                    n_didx = r_rd[IW-1:0];
                end
                if (match) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_didx;
                    mem_wdata = '{start: r_faddr, free: 1'b1};
                    n_status  = ffsa_pkg::ST_OK;
                end
            end
            ffsa_pkg::A_EMIT: begin
                if (flags.out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ogrant  = (r_status == ffsa_pkg::ST_OK) ? r_grant : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[r_rd[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_words <= ffsa_pkg::MEM_WORDS_RESET;
            r_count     <= CW'(1);
            r_dv        <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_mem_words <= n_mem_words;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_size      <= n_size;
        r_faddr     <= n_faddr;
        r_rd        <= n_rd;
        r_didx      <= n_didx;
        r_wr        <= n_wr;
        r_prev_s    <= n_prev_s;
        r_prev_f    <= n_prev_f;
        r_fit_found <= n_fit_found;
        r_fit_idx   <= n_fit_idx;
        r_fit_start <= n_fit_start;
        r_fit_len   <= n_fit_len;
        r_status    <= n_status;
        r_grant     <= n_grant;
        r_ostatus   <= n_ostatus;
        r_ogrant    <= n_ogrant;
    end

    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.status          = r_ostatus;
    assign o_rsp.granted_address = r_ogrant;

    `FFSA_ASSERT(a_count_range, i_clk, i_rst_n,
        (r_count != '0) && (r_count <= CW'(MAX_SEGMENTS)))
    `FFSA_ASSERT(a_one_in_work, i_clk, i_rst_n,
        accept |=> !i_req.ready)
    `FFSA_ASSERT(a_write_in_table, i_clk, i_rst_n,
        mem_we |-> (CW'(mem_waddr) < r_count))
    `FFSA_ASSERT_MSG(a_grant_only_ok, i_clk, i_rst_n,
        (r_ovalid && (r_ostatus != ffsa_pkg::ST_OK)) |-> (r_ogrant == '0),
        "granted address set on a failed request")

endmodule
